@@ sv/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ sv/hsvrgb_pkg.sv @@
`default_nettype none

package hsvrgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int HUE_BITS  = 16;
    localparam int FIELD_W   = FRAC_BITS + 1;

    // 1.0 in the unsigned fixed-point format of the color fields
    localparam logic [FIELD_W-1:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        logic [FIELD_W-1:0]  saturation;
        logic [FIELD_W-1:0]  brightness;
        logic                last_item;
    } t_hsv_beat;

    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
        logic [FIELD_W-1:0] alpha_out;
        logic               last_out;
    } t_rgba_beat;

endpackage

`default_nettype wire

@@ sv/hsvrgb_ram.sv @@
`default_nettype none

module hsvrgb_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4097,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold the read word while the reader is stalled
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ sv/hsv_to_rgb_gamma_top.sv @@
// HSV to gamma-encoded RGBA converter.
// Input channel: i_in_valid / o_in_stall carry one HSV beat (hue as a fraction
// of a full turn, saturation and value with 1.0 = 4096, a last marker).
// Output channel: o_out_valid / i_out_stall carry one RGBA beat per input beat
// in the same order; alpha comes from the alpha register, last is copied.
// A beat moves on a rising edge where valid is high and stall is low.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the alpha register on
// the same edge; values above 1.0 are clamped. Write it only while idle.
// Pipeline: four register stages (hue sector and weight, chroma multiply,
// X multiply, gamma lookup with registered RAM read). An accepted beat moves
// through the stage 1, 2 and 3 registers and the RAM read register in turn to
// the output. Throughput is one beat per clock while o_in_stall stays low.
// Reset: synchronous, active low. After reset the three gamma RAMs are filled
// by a sweep that walks the table once in input and once in output steps,
// with o_in_stall held high throughout.
// Receiver stall: when the output beat is stalled, the whole pipeline holds;
// nothing is dropped or repeated and o_in_stall rises in the same cycle.
`default_nettype none

`include "assert_macros.svh"

module hsv_to_rgb_gamma_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire hsvrgb_pkg::t_hsv_beat           i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output hsvrgb_pkg::t_rgba_beat               o_out_data,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [hsvrgb_pkg::FIELD_W-1:0]  i_cfg_wr_data
);

    import hsvrgb_pkg::*;

    localparam int FW = FIELD_W;
    localparam int HW = HUE_BITS;
    localparam int XW = FW + HW + 1;

    // Gamma fill: p(y) = (2y+1)^11 against q(x) * 2^(11 + 6*FRAC_BITS), q(x) = x^5.
    localparam int PW  = 11 * (FRAC_BITS + 2) + 2;
    localparam int QW  = 5 * FRAC_BITS + 6;
    localparam int RSH = 11 + 6 * FRAC_BITS;
    localparam int PN  = 12;
    localparam int QN  = 6;

    localparam logic [HW:0]     HUE_TURN = {1'b1, {HW{1'b0}}};
    localparam logic [2*FW-1:0] C_RND    = (2 * FW)'(1) << (FRAC_BITS - 1);
    localparam logic [XW-1:0]   X_RND    = XW'(1) << (HW - 1);

    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;

    typedef logic [PW-1:0] t_pd_vec [PN];
    typedef logic [QW-1:0] t_qd_vec [QN];
    typedef enum logic {ST_FILL, ST_RUN} t_state;

    // Forward difference of order k at 0 of (2j+1)^pw or j^pw.
    function automatic longint fwd_diff(input int k, input int pw, input bit odd);
        longint vals [PN];
        longint b;
        int     i;
        int     j;
        for (i = 0; i < PN; i++) begin
            b = odd ? longint'(2 * i + 1) : longint'(i);
            vals[i] = 1;
            for (j = 0; j < pw; j++) begin
                vals[i] = vals[i] * b;
            end
        end
        for (j = 0; j < k; j++) begin
            for (i = 0; i < PN - 1 - j; i++) begin
                vals[i] = vals[i + 1] - vals[i];
            end
        end
        return vals[0];
    endfunction

    function automatic t_pd_vec init_pd();
        t_pd_vec v;
        for (int k = 0; k < PN; k++) begin
            v[k] = PW'($unsigned(fwd_diff(k, 11, 1'b1)));
        end
        return v;
    endfunction

    function automatic t_qd_vec init_qd();
        t_qd_vec v;
        for (int k = 0; k < QN; k++) begin
            v[k] = QW'($unsigned(fwd_diff(k, 5, 1'b0)));
        end
        return v;
    endfunction

    localparam t_pd_vec PD_INIT = init_pd();
    localparam t_qd_vec QD_INIT = init_qd();

    // ---------------------------------------------------------------
    // Table fill after reset. Two pointers walk x (RAM address) and y
    // (candidate output); y advances while (2y+1)^11 fits under the bound
    // for x, otherwise y is written at x and x advances. Both powers are
    // tracked by forward differences, so each step is one wide add per term.
    // ---------------------------------------------------------------
    t_state          r_state;
    logic [FW-1:0]   r_fx;
    logic [FW-1:0]   r_fy;
    t_pd_vec         r_pd;
    t_qd_vec         r_qd;
    logic [PW-1:0]   w_rhs;
    logic            w_y_step;
    logic            w_fill_wr;

    assign w_rhs     = PW'(r_qd[0]) << RSH;
    assign w_y_step  = (r_state == ST_FILL) && (r_fy != FIX_ONE) && (r_pd[0] <= w_rhs);
    assign w_fill_wr = (r_state == ST_FILL) && !w_y_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_fx    <= '0;
            r_fy    <= '0;
            r_pd    <= PD_INIT;
            r_qd    <= QD_INIT;
        end else begin
            unique case (r_state)
                ST_FILL: begin
                    if (w_y_step) begin
                        r_fy <= FW'(r_fy + 1'b1);
                        for (int k = 0; k < PN - 1; k++) begin
                            r_pd[k] <= r_pd[k] + r_pd[k + 1];
                        end
                    end else if (r_fx == FIX_ONE) begin
                        r_state <= ST_RUN;
                    end else begin
                        r_fx <= FW'(r_fx + 1'b1);
                        for (int k = 0; k < QN - 1; k++) begin
                            r_qd[k] <= r_qd[k] + r_qd[k + 1];
                        end
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Alpha register, clamped to 1.0 on write.
    // ---------------------------------------------------------------
    logic [FW-1:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= FIX_ONE;
        end else if (i_cfg_wr_en) begin
            r_alpha <= (i_cfg_wr_data > FIX_ONE) ? FIX_ONE : i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: all stages advance together unless the output
    // beat is stalled. Valid bits travel with the data.
    // ---------------------------------------------------------------
    logic w_adv;
    logic w_in_acc;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    assign w_adv      = !(r_v4 && i_out_stall);
    assign o_in_stall = !w_adv || (r_state != ST_RUN);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_in_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage 1: clamp s and v, split hue*6 into sector and fraction, and
    // mirror the fraction in odd sectors.
    logic [HW+2:0] w_h6;
    logic [HW-1:0] w_frac;
    logic [HW:0]   n_s1_w;
    logic [FW-1:0] n_s1_sat;
    logic [FW-1:0] n_s1_val;

    assign w_h6   = (HW + 3)'({i_in_data.hue, 2'b00}) + (HW + 3)'({i_in_data.hue, 1'b0});
    assign w_frac = w_h6[HW-1:0];
    assign n_s1_w = w_h6[HW] ? (HUE_TURN - (HW + 1)'(w_frac)) : (HW + 1)'(w_frac);
    assign n_s1_sat = (i_in_data.saturation > FIX_ONE) ? FIX_ONE : i_in_data.saturation;
    assign n_s1_val = (i_in_data.brightness > FIX_ONE) ? FIX_ONE : i_in_data.brightness;

    logic [FW-1:0] r_s1_sat;
    logic [FW-1:0] r_s1_val;
    logic [HW:0]   r_s1_w;
    logic [2:0]    r_s1_sector;
    logic          r_s1_last;

    // Stage 2: chroma = s*v, rounded.
    logic [2*FW-1:0] w_cprod;
    logic [FW-1:0]   n_s2_c;

    assign w_cprod = (2 * FW)'(r_s1_sat) * (2 * FW)'(r_s1_val);
    assign n_s2_c  = FW'((w_cprod + C_RND) >> FRAC_BITS);

    logic [FW-1:0] r_s2_c;
    logic [FW-1:0] r_s2_v;
    logic [HW:0]   r_s2_w;
    logic [2:0]    r_s2_sector;
    logic          r_s2_last;

    // Stage 3: X = chroma * weight, rounded; offset m = v - chroma.
    logic [XW-1:0] w_xprod;
    logic [FW-1:0] n_s3_x;

    assign w_xprod = XW'(r_s2_c) * XW'(r_s2_w);
    assign n_s3_x  = FW'((w_xprod + X_RND) >> HW);

    logic [FW-1:0] r_s3_c;
    logic [FW-1:0] r_s3_x;
    logic [FW-1:0] r_s3_m;
    logic [2:0]    r_s3_sector;
    logic          r_s3_last;
    logic          r_s4_last;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_sat    <= n_s1_sat;
            r_s1_val    <= n_s1_val;
            r_s1_w      <= n_s1_w;
            r_s1_sector <= w_h6[HW+2:HW];
            r_s1_last   <= i_in_data.last_item;

            r_s2_c      <= n_s2_c;
            r_s2_v      <= r_s1_val;
            r_s2_w      <= r_s1_w;
            r_s2_sector <= r_s1_sector;
            r_s2_last   <= r_s1_last;

            r_s3_c      <= r_s2_c;
            r_s3_x      <= n_s3_x;
            r_s3_m      <= r_s2_v - r_s2_c;
            r_s3_sector <= r_s2_sector;
            r_s3_last   <= r_s2_last;

            r_s4_last   <= r_s3_last;
        end
    end

    // Place chroma and X by sector, add the offset, clamp: these are the
    // gamma RAM addresses for red, green and blue.
    logic [FW-1:0] w_base    [3];
    logic [FW:0]   w_sum     [3];
    logic [FW-1:0] w_rd_addr [3];
    logic [FW-1:0] w_rd_data [3];

    always_comb begin
        w_base[0] = '0;
        w_base[1] = '0;
        w_base[2] = '0;
        unique case (r_s3_sector)
            SEC_RED_YEL: begin
                w_base[0] = r_s3_c;
                w_base[1] = r_s3_x;
            end
            SEC_YEL_GRN: begin
                w_base[0] = r_s3_x;
                w_base[1] = r_s3_c;
            end
            SEC_GRN_CYN: begin
                w_base[1] = r_s3_c;
                w_base[2] = r_s3_x;
            end
            SEC_CYN_BLU: begin
                w_base[1] = r_s3_x;
                w_base[2] = r_s3_c;
            end
            SEC_BLU_MAG: begin
                w_base[0] = r_s3_x;
                w_base[2] = r_s3_c;
            end
            default: begin
                w_base[0] = r_s3_c;
                w_base[2] = r_s3_x;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            w_sum[i]     = (FW + 1)'(w_base[i]) + (FW + 1)'(r_s3_m);
            w_rd_addr[i] = (w_sum[i] > (FW + 1)'(FIX_ONE)) ? FIX_ONE : FW'(w_sum[i]);
        end
    end

    // Stage 4: gamma lookup, one RAM per channel, all filled with the same
    // table during the sweep.
    for (genvar g = 0; g < 3; g++) begin : g_gamma
        hsvrgb_ram #(
            .WIDTH (FW),
            .DEPTH (2 ** FRAC_BITS + 1)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (w_fill_wr),
            .i_wr_addr (r_fx),
            .i_wr_data (r_fy),
            .i_rd_en   (w_adv),
            .i_rd_addr (w_rd_addr[g]),
            .o_rd_data (w_rd_data[g])
        );
    end

    assign o_out_valid = r_v4;

    always_comb begin
        o_out_data.red       = w_rd_data[0];
        o_out_data.green     = w_rd_data[1];
        o_out_data.blue      = w_rd_data[2];
        o_out_data.alpha_out = r_alpha;
        o_out_data.last_out  = r_s4_last;
    end

    `ASSERT_PROP(a_stall_holds_valids, i_clk, i_rst_n, (r_v4 && i_out_stall) |=> $stable({r_v1, r_v2, r_v3, r_v4}), "pipeline valids moved during an output stall")
    `ASSERT_PROP(a_fill_y_monotone, i_clk, i_rst_n, (r_state == ST_FILL) |=> (r_fy >= $past(r_fy)), "gamma fill output went backward")
    `ASSERT_PROP(a_run_persists, i_clk, i_rst_n, (r_state == ST_RUN) |=> (r_state == ST_RUN), "table fill restarted without reset")
    `ASSERT_NEVER(a_addr_in_range, i_clk, i_rst_n, r_v3 && ((w_rd_addr[0] > FIX_ONE) || (w_rd_addr[1] > FIX_ONE) || (w_rd_addr[2] > FIX_ONE)), "gamma address above 1.0")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

// Testbench for hsv_to_rgb_gamma_top.
// Every beat that the block accepts is converted here as well, from hue
// sector, chroma and X down to the gamma table, and the expected RGBA beat is
// queued. Each RGBA beat that leaves the block is checked field by field
// against the oldest queued one. Both channels idle in random bursts; one test
// holds the output off for a long stretch and another drains between bursts.
module tb;
    import hsvrgb_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 9;
    // Covers the gamma RAM fill after reset, ~630 beats with gaps and stalls
    // on both sides, and the long hold-off, with a wide margin.
    localparam int CYCLE_LIMIT = 200000;
    localparam int GAMMA_DEPTH = (1 << FRAC_BITS) + 1;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_stall;
    t_hsv_beat  i_in_data     = '0;
    logic       o_out_valid;
    logic       i_out_stall   = 1'b0;
    t_rgba_beat o_out_data;
    logic       i_cfg_wr_en   = 1'b0;
    logic [FIELD_W-1:0] i_cfg_wr_data = '0;

    // Converted beats still owed by the block, oldest first.
    t_rgba_beat pending_rgba[$];
    // Our copy of the alpha register and the x^(1/2.2) table.
    logic [FIELD_W-1:0] alpha_shadow;
    logic [FIELD_W-1:0] gamma_lut [0:GAMMA_DEPTH-1];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  tx_idle_en     = 1'b0;
    bit  rx_idle_en     = 1'b0;
    int  rx_hold_len    = 0;

    hsv_to_rgb_gamma_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Give up if the run hangs; no beat may be lost or stuck.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    function automatic logic [159:0] wide_pow(int unsigned base, int expo);
        logic [159:0] acc;
        acc = 160'd1;
        for (int k = 0; k < expo; k++)
            acc = acc * base;
        return acc;
    endfunction

    // Fill the gamma table with the nearest integer to ONE*(x/ONE)^(5/11),
    // ties upward. y is the largest value with (2y-1)^11 <= 2^11 x^5 ONE^6;
    // the table is monotonic, so walk y upward as x grows.
    function automatic void build_gamma_lut();
        logic [159:0] bound;
        int y;
        y = 0;
        for (int x = 0; x < GAMMA_DEPTH; x++) begin
            bound = wide_pow(x, 5) << (11 + 6 * FRAC_BITS);
            while (y < (1 << FRAC_BITS)) begin
                if (wide_pow(2 * y + 1, 11) <= bound)
                    y++;
                else
                    break;
            end
            gamma_lut[x] = y[FIELD_W-1:0];
        end
    endfunction

    function automatic int unsigned clamp_unit(int unsigned x);
        return (x > FIX_ONE) ? FIX_ONE : x;
    endfunction

    function automatic t_rgba_beat predict_rgba(t_hsv_beat px);
        int unsigned sat, val, hue6, sector, frac, chroma, weight, xval, lift;
        int unsigned rr, gg, bb;
        t_rgba_beat res;
        sat    = clamp_unit(px.saturation);
        val    = clamp_unit(px.brightness);
        hue6   = px.hue * 6;
        sector = hue6 >> HUE_BITS;
        frac   = hue6 % (1 << HUE_BITS);
        chroma = (sat * val + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        // rising edge of the ramp in even sectors, falling edge in odd ones
        weight = (sector % 2 == 1) ? (1 << HUE_BITS) - frac : frac;
        xval   = (chroma * weight + (1 << (HUE_BITS - 1))) >> HUE_BITS;
        lift   = val - chroma;
        case (sector)
            0:       begin rr = chroma; gg = xval;   bb = 0;      end
            1:       begin rr = xval;   gg = chroma; bb = 0;      end
            2:       begin rr = 0;      gg = chroma; bb = xval;   end
            3:       begin rr = 0;      gg = xval;   bb = chroma; end
            4:       begin rr = xval;   gg = 0;      bb = chroma; end
            default: begin rr = chroma; gg = 0;      bb = xval;   end
        endcase
        res.red       = gamma_lut[clamp_unit(rr + lift)];
        res.green     = gamma_lut[clamp_unit(gg + lift)];
        res.blue      = gamma_lut[clamp_unit(bb + lift)];
        res.alpha_out = FIELD_W'(clamp_unit(alpha_shadow));
        res.last_out  = px.last_item;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compare every RGBA beat that moves against the oldest expectation.
    always @(posedge i_clk) begin : check_rgba
        t_rgba_beat want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_rgba.size() == 0) begin
                report_mismatch("beat with nothing pending", 1, 0);
            end else begin
                want = pending_rgba.pop_front();
                if (o_out_data.red !== want.red)
                    report_mismatch("red", o_out_data.red, want.red);
                if (o_out_data.green !== want.green)
                    report_mismatch("green", o_out_data.green, want.green);
                if (o_out_data.blue !== want.blue)
                    report_mismatch("blue", o_out_data.blue, want.blue);
                if (o_out_data.alpha_out !== want.alpha_out)
                    report_mismatch("alpha", o_out_data.alpha_out, want.alpha_out);
                if (o_out_data.last_out !== want.last_out)
                    report_mismatch("last", o_out_data.last_out, want.last_out);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random stall bursts, or one long hold when asked for
    // ---------------------------------------------------------------------

    initial begin : drive_out_stall
        int hold;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                // hold off for the whole stretch so the pipeline backs up
                hold        = rx_hold_len;
                rx_hold_len = 0;
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender and configuration
    // ---------------------------------------------------------------------

    // Offer one HSV beat, maybe after a random gap, and keep valid high on
    // return so that the next beat can follow back to back.
    task automatic send_hsv(t_hsv_beat px);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        // hold the beat until the block takes it
        do @(posedge i_clk); while (o_in_stall);
        pending_rgba.push_back(predict_rgba(px));
    endtask

    // Drop valid and wait until every owed beat has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_rgba.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the alpha register; only call with the pipeline empty.
    task automatic write_alpha(logic [FIELD_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        alpha_shadow = value;
    endtask

    function automatic t_hsv_beat make_hsv(int unsigned hue, int unsigned sat,
                                           int unsigned val, bit last);
        t_hsv_beat px;
        px.hue        = hue[HUE_BITS-1:0];
        px.saturation = sat[FIELD_W-1:0];
        px.brightness = val[FIELD_W-1:0];
        px.last_item  = last;
        return px;
    endfunction

    // Mostly in range, sometimes the ends, sometimes above 1.0.
    function automatic int unsigned random_level();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom_range(0, 1) ? FIX_ONE : 0;
        if (pick == 1)
            return $urandom_range(0, (1 << FIELD_W) - 1);
        return $urandom_range(0, FIX_ONE);
    endfunction

    function automatic t_hsv_beat random_hsv();
        return make_hsv($urandom, random_level(), random_level(), $urandom_range(0, 1));
    endfunction

    function automatic logic [FIELD_W-1:0] random_alpha();
        case ($urandom_range(0, 3))
            0:       return FIX_ONE;
            1:       return FIELD_W'($urandom_range(FIX_ONE, (1 << FIELD_W) - 1));
            default: return FIELD_W'($urandom_range(0, FIX_ONE));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset alpha; hue at both ends and on each side of every sector border,
    // zero and full saturation and value, both above 1.0, both last values.
    task automatic test_directed_corners();
        send_hsv(make_hsv(0,     4096, 4096, 0));
        send_hsv(make_hsv(65535, 4096, 4096, 1));
        send_hsv(make_hsv(10922, 4096, 4096, 0));
        send_hsv(make_hsv(10923, 4096, 4096, 0));
        send_hsv(make_hsv(21845, 4096, 4096, 0));
        send_hsv(make_hsv(21846, 4096, 4096, 1));
        send_hsv(make_hsv(32767, 4096, 4096, 0));
        send_hsv(make_hsv(32768, 4096, 4096, 0));
        send_hsv(make_hsv(43690, 4096, 4096, 0));
        send_hsv(make_hsv(43691, 4096, 4096, 1));
        send_hsv(make_hsv(54613, 4096, 4096, 0));
        send_hsv(make_hsv(54614, 4096, 4096, 0));
        send_hsv(make_hsv(12345, 0,    4096, 0));
        send_hsv(make_hsv(20000, 4096, 0,    1));
        send_hsv(make_hsv(30000, 8191, 4096, 0));
        send_hsv(make_hsv(40000, 4096, 8191, 0));
        send_hsv(make_hsv(50000, 8191, 8191, 1));
        send_hsv(make_hsv(5000,  4097, 6000, 0));
        send_hsv(make_hsv(60000, 1,    1,    1));
        send_hsv(make_hsv(1,     2048, 2048, 0));
        send_hsv(make_hsv(43000, 0,    0,    0));
    endtask

    // Walk alpha through zero, 1.0, just above, the top code and a random one.
    task automatic test_alpha_settings();
        logic [FIELD_W-1:0] settings [5];
        settings = '{FIELD_W'(0), FIX_ONE, FIELD_W'(FIX_ONE + 1),
                     FIELD_W'((1 << FIELD_W) - 1), random_alpha()};
        foreach (settings[i]) begin
            wait_drained();
            write_alpha(settings[i]);
            repeat (6) send_hsv(random_hsv());
        end
    endtask

    // Bulk random beats in chunks; idling switches per chunk, alpha changes
    // before every second chunk once the pipeline is empty.
    task automatic test_random_stream();
        for (int chunk = 0; chunk < 6; chunk++) begin
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
            if (chunk % 2 == 1) begin
                wait_drained();
                write_alpha(random_alpha());
            end
            repeat (75) send_hsv(random_hsv());
        end
    endtask

    // Hold the output off for a long stretch while beats keep coming, so the
    // pipeline fills and the input stalls.
    task automatic test_backpressure();
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_len = 60;
        repeat (30) send_hsv(random_hsv());
    endtask

    // Send short bursts and let every result come out before the next.
    task automatic test_drain_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int burst = 0; burst < 5; burst++) begin
            repeat (8) send_hsv(random_hsv());
            wait_drained();
        end
    endtask

    // Close with full rate on both sides.
    task automatic test_full_rate_tail();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (60) send_hsv(random_hsv());
    endtask

    initial begin
        alpha_shadow = FIX_ONE;
        build_gamma_lut();
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the first beat waits out the gamma RAM fill
        test_directed_corners();
        test_alpha_settings();
        test_random_stream();
        test_backpressure();
        test_drain_pause();
        test_full_rate_tail();

        wait_drained();
        // keep the clock running so that any stray beat can still show up
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rgba.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
